// ===== design/qts_pkg.sv =====
// Package for the quad-to-triangle splitter: point types, stage payloads,
// register indexes and the sort compare and squared-distance helpers.
`default_nettype none
package qts_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned DistW  = 66;
  localparam int unsigned SortMarginW = 16;
  localparam int unsigned SameMarginW = 32;
  localparam logic [SortMarginW-1:0] SortMarginReset = 16'd7;
  localparam logic [SameMarginW-1:0] SameMarginReset = 32'd43;
  localparam int unsigned FifoDepth = 4;

  typedef enum logic [0:0] {
    REG_SORT_MARGIN = 1'b0,
    REG_SAME_MARGIN = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } point_t;

  typedef struct packed {
    point_t p0;
    point_t p1;
    point_t p2;
    point_t p3;
  } quad_t;

  typedef struct packed {
    point_t v0;
    point_t v1;
    point_t v2;
    logic   collapsed;
    logic   last;
  } tri_t;

  typedef struct packed {
    point_t [3:0] p;
    logic [5:0][DistW-1:0] d;
  } dist_beat_t;

  // squared component difference, 66 bits
  function automatic logic [DistW-1:0] sq_diff(logic signed [CoordW-1:0] a,
                                                logic signed [CoordW-1:0] b);
    logic signed [CoordW:0] d;
    logic [CoordW:0] m;
    logic [2*CoordW+1:0] s;
    d = {a[CoordW-1], a} - {b[CoordW-1], b};
    m = d[CoordW] ? -d : d;
    s = m * m;
    return DistW'(s);
  endfunction

  // one compare component: 2 swap, 1 keep, 0 undecided
  function automatic logic [1:0] cmp_comp(logic signed [CoordW-1:0] a,
                                          logic signed [CoordW-1:0] b,
                                          logic [SortMarginW-1:0] m);
    logic signed [CoordW+1:0] dab;
    logic signed [CoordW+1:0] dba;
    logic signed [CoordW+1:0] mm;
    dab = {{2{a[CoordW-1]}}, a} - {{2{b[CoordW-1]}}, b};
    dba = -dab;
    mm  = {{(CoordW+2-SortMarginW){1'b0}}, m};
    if (dab >= mm) return 2'd2;
    if (dba >= mm) return 2'd1;
    return 2'd0;
  endfunction

  function automatic logic must_swap(point_t a, point_t b, logic [SortMarginW-1:0] m);
    logic [1:0] cx;
    logic [1:0] cy;
    cx = cmp_comp(a.x, b.x, m);
    cy = cmp_comp(a.y, b.y, m);
    if (cx != 2'd0) return cx == 2'd2;
    if (cy != 2'd0) return cy == 2'd2;
    return cmp_comp(a.z, b.z, m) == 2'd2;
  endfunction

endpackage
`default_nettype wire

// ===== design/qts_if.sv =====
// Valid/ready channel interface with a generic payload type.
// Depends on nothing; payload types come from qts_pkg at instantiation.
`default_nettype none
interface qts_if #(parameter type T = logic) (input wire logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/qts_sort.sv =====
// Bubble-sort network: one pass of three compare-swaps per register stage.
// Depends on qts_pkg.
`default_nettype none
module qts_sort (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             advance,
  input  wire logic                             in_valid,
  input  wire qts_pkg::quad_t                   in_quad,
  input  wire logic [qts_pkg::SortMarginW-1:0]  margin,
  output logic                                  out_valid,
  output qts_pkg::point_t [3:0]                 out_p
);
  localparam int unsigned Passes = 4;

  logic [Passes-1:0]           vld;
  qts_pkg::point_t [3:0]       stg [Passes];
  qts_pkg::point_t [3:0]       src [Passes];

  // feed each pass from the previous stage, the first from the input beat
  always_comb begin
    for (int s = 0; s < Passes; s++) begin
      if (s == 0) src[s] = {in_quad.p3, in_quad.p2, in_quad.p1, in_quad.p0};
      else        src[s] = stg[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[Passes-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int s = 0; s < Passes; s++) stg[s] <= swap_pass(src[s]);
    end
  end

  function automatic qts_pkg::point_t [3:0] swap_pass(qts_pkg::point_t [3:0] a);
    qts_pkg::point_t [3:0] r;
    qts_pkg::point_t t;
    r = a;
    for (int j = 0; j < 3; j++) begin
      if (qts_pkg::must_swap(r[j], r[j+1], margin)) begin
        t = r[j]; r[j] = r[j+1]; r[j+1] = t;
      end
    end
    return r;
  endfunction

  assign out_valid = vld[Passes-1];
  assign out_p     = stg[Passes-1];
endmodule
`default_nettype wire

// ===== design/qts_dist.sv =====
// Pairwise squared distances, split over two register stages:
// component squares, then sums. Depends on qts_pkg.
`default_nettype none
module qts_dist (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   advance,
  input  wire logic                   in_valid,
  input  wire qts_pkg::point_t [3:0]  in_p,
  output logic                        out_valid,
  output qts_pkg::dist_beat_t         out_beat
);
  logic                              v1;
  qts_pkg::point_t [3:0]             p1;
  logic [5:0][2:0][qts_pkg::DistW-1:0] sq;

  // square each component difference, then sum the squares per pair
  always_ff @(posedge clk) begin
    if (advance) begin
      p1 <= in_p;
      for (int k = 0; k < 6; k++) begin
        sq[k][0] <= qts_pkg::sq_diff(in_p[pa(k)].x, in_p[pb(k)].x);
        sq[k][1] <= qts_pkg::sq_diff(in_p[pa(k)].y, in_p[pb(k)].y);
        sq[k][2] <= qts_pkg::sq_diff(in_p[pa(k)].z, in_p[pb(k)].z);
      end
      out_beat.p <= p1;
      for (int k = 0; k < 6; k++) out_beat.d[k] <= sq[k][0] + sq[k][1] + sq[k][2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1 <= in_valid;
      out_valid <= v1;
    end
  end

  // pair order (0,1),(0,2),(0,3),(1,2),(1,3),(2,3)
  function automatic logic [1:0] pa(int k);
    return (k < 3) ? 2'd0 : (k < 5) ? 2'd1 : 2'd2;
  endfunction
  function automatic logic [1:0] pb(int k);
    case (k)
      0: return 2'd1;
      1: return 2'd2;
      2: return 2'd3;
      3: return 2'd2;
      4: return 2'd3;
      default: return 2'd3;
    endcase
  endfunction
endmodule
`default_nettype wire

// ===== design/qts_pick.sv =====
// Pair scan, neighbor choice and triangle assembly over two stages.
// Depends on qts_pkg. Outputs first and second triangle plus a two-triangle flag.
`default_nettype none
module qts_pick (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              advance,
  input  wire logic                              in_valid,
  input  wire qts_pkg::dist_beat_t               in_beat,
  input  wire logic [qts_pkg::SameMarginW-1:0]   margin,
  output logic                                   out_valid,
  output qts_pkg::tri_t                          out_t0,
  output qts_pkg::tri_t                          out_t1,
  output logic                                   out_two
);
  localparam int unsigned DW = qts_pkg::DistW;

  // stage A: scan result
  logic                  va;
  logic                  coll_a;
  logic [1:0]            coll_i;
  logic [1:0]            start_i;
  logic [1:0]            rest_sel;
  qts_pkg::point_t [3:0] pa;
  logic [5:0][DW-1:0]    da;

  logic                  coll_c;
  logic [1:0]            coll_ic;
  logic [1:0]            start_c;
  logic [2:0]            best_c;
  logic [DW-1:0]         best_d;

  // scan pairs in order for coinciding corners and the farthest pair
  always_comb begin
    coll_c  = 1'b0;
    coll_ic = 2'd0;
    best_d  = '0;
    best_c  = 3'd0;
    start_c = 2'd0;
    for (int k = 0; k < 6; k++) begin
      if (!coll_c) begin
        if (in_beat.d[k] < {{(DW-qts_pkg::SameMarginW){1'b0}}, margin}) begin
          coll_c  = 1'b1;
          coll_ic = (k < 3) ? 2'd0 : (k < 5) ? 2'd1 : 2'd2;
        end else if (best_d < in_beat.d[k]) begin
          best_d  = in_beat.d[k];
          best_c  = 3'(k);
          start_c = (k < 3) ? 2'd0 : (k < 5) ? 2'd1 : 2'd2;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      coll_a  <= coll_c;
      coll_i  <= coll_ic;
      start_i <= start_c;
      rest_sel <= (best_c == 3'd3 || best_c == 3'd4) ? 2'd1 :
                  (best_c == 3'd5) ? 2'd2 : 2'd0;
      pa <= in_beat.p;
      da <= in_beat.d;
    end
  end

  // distance from point i to point j, from the pair table
  function automatic logic [DW-1:0] dd(logic [5:0][DW-1:0] d, logic [1:0] i,
                                       logic [1:0] j);
    logic [3:0] key;
    key = (i < j) ? {i, j} : {j, i};
    case (key)
      4'b0001: return d[0];
      4'b0010: return d[1];
      4'b0011: return d[2];
      4'b0110: return d[3];
      4'b0111: return d[4];
      4'b1011: return d[5];
      default: return '0;
    endcase
  endfunction

  // closest two among three candidates; returns {n1, n2, far} indexes
  function automatic logic [5:0] pick(logic [5:0][DW-1:0] d, logic [1:0] from,
                                      logic [1:0] c0, logic [1:0] c1,
                                      logic [1:0] c2);
    logic [DW-1:0] d0;
    logic [DW-1:0] d1;
    logic [DW-1:0] d2;
    d0 = dd(d, from, c0);
    d1 = dd(d, from, c1);
    d2 = dd(d, from, c2);
    if (d0 <= d2 && d1 <= d2) return {c0, c1, c2};
    if (d1 <= d0 && d2 <= d0) return {c1, c2, c0};
    return {c0, c2, c1};
  endfunction

  logic [1:0] r0;
  logic [1:0] r1;
  logic [1:0] r2;
  logic [5:0] f1;
  logic [5:0] f2;
  logic [1:0] ca;
  logic [1:0] cb;

  // build both triangles from indexes
  always_comb begin
    case (rest_sel)
      2'd1:    begin r0 = 2'd0; r1 = 2'd2; r2 = 2'd3; end
      2'd2:    begin r0 = 2'd0; r1 = 2'd1; r2 = 2'd3; end
      default: begin r0 = 2'd1; r1 = 2'd2; r2 = 2'd3; end
    endcase
    f1 = pick(da, start_i, r0, r1, r2);
    f2 = pick(da, f1[1:0], f1[5:4], f1[3:2], start_i);
    case (coll_i)
      2'd0:    begin ca = 2'd1; cb = 2'd2; end
      2'd1:    begin ca = 2'd0; cb = 2'd2; end
      default: begin ca = 2'd0; cb = 2'd1; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (coll_a) begin
        out_t0 <= '{v0: pa[ca], v1: pa[cb], v2: pa[3], collapsed: 1'b1, last: 1'b1};
        out_two <= 1'b0;
      end else begin
        out_t0 <= '{v0: pa[start_i], v1: pa[f1[5:4]], v2: pa[f1[3:2]],
                    collapsed: 1'b0, last: 1'b0};
        out_two <= 1'b1;
      end
      out_t1 <= '{v0: pa[f1[1:0]], v1: pa[f2[5:4]], v2: pa[f2[3:2]],
                  collapsed: 1'b0, last: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      va <= in_valid;
      out_valid <= va;
    end
  end
endmodule
`default_nettype wire

// ===== design/quad_to_triangle_split_top.sv =====
// Top level of the quad-to-triangle splitter: config registers, pipeline,
// output serializer. Depends on qts_pkg, qts_if, qts_sort, qts_dist, qts_pick.
//
//  channel  | role   | beat
//  ---------+--------+------------------------------------------
//  quad     | sink   | four corners (qts_pkg::quad_t)
//  triangle | source | one triangle with collapsed and last flags
//  cfg      | sink   | register index and write data
//
// There are 9 register stages from quad beat to first triangle beat (4 sort,
// 2 distance, 2 pick, 1 output buffer). One quad enters per cycle while the
// pipe flows; each quad leaves one or two triangle beats, so the triangle port
// sets the rate. The pipe stalls as a whole while the output pair buffer is
// busy and the pick stage holds a valid result; nothing is dropped.
// Reset (rst, synchronous) clears valid bits and loads register defaults.
`default_nettype none
module quad_to_triangle_split_top (
  input  wire logic clk,
  input  wire logic rst,
  qts_if.sink       quad,
  qts_if.source     triangle,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [0:0]        cfg_index,
  input  wire logic [31:0]       cfg_data
);
  logic [qts_pkg::SortMarginW-1:0] sort_margin;
  logic [qts_pkg::SameMarginW-1:0] same_margin;

  // write configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      sort_margin <= qts_pkg::SortMarginReset;
      same_margin <= qts_pkg::SameMarginReset;
    end else if (cfg_valid) begin
      case (qts_pkg::reg_idx_t'(cfg_index))
        qts_pkg::REG_SORT_MARGIN: sort_margin <= cfg_data[qts_pkg::SortMarginW-1:0];
        qts_pkg::REG_SAME_MARGIN: same_margin <= cfg_data;
        default: ;
      endcase
    end
  end

  logic                  advance;
  logic                  s_valid;
  qts_pkg::point_t [3:0] s_p;
  logic                  d_valid;
  qts_pkg::dist_beat_t   d_beat;
  logic                  k_valid;
  qts_pkg::tri_t         k_t0;
  logic                  k_two;
  qts_pkg::tri_t         k_t1;

  // output pair buffer
  logic          hold;
  logic          hold_two;
  logic          sent_first;
  qts_pkg::tri_t h_t0;
  qts_pkg::tri_t h_t1;
  logic          done;

  assign done    = hold && triangle.ready && (!hold_two || sent_first);
  assign advance = !hold || done || !k_valid;
  assign quad.ready = advance;

  qts_sort u_sort (
    .clk, .rst, .advance, .in_valid(quad.valid), .in_quad(quad.data),
    .margin(sort_margin), .out_valid(s_valid), .out_p(s_p)
  );
  qts_dist u_dist (
    .clk, .rst, .advance, .in_valid(s_valid), .in_p(s_p),
    .out_valid(d_valid), .out_beat(d_beat)
  );
  qts_pick u_pick (
    .clk, .rst, .advance, .in_valid(d_valid), .in_beat(d_beat),
    .margin(same_margin), .out_valid(k_valid), .out_t0(k_t0), .out_t1(k_t1),
    .out_two(k_two)
  );

  // load pair buffer from pipe, drain one triangle per beat
  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= 1'b0;
      sent_first <= 1'b0;
    end else begin
      if (hold && triangle.ready && hold_two && !sent_first) sent_first <= 1'b1;
      if (done || !hold) begin
        hold <= advance && k_valid;
        sent_first <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((done || !hold) && advance) begin
      h_t0 <= k_t0;
      h_t1 <= k_t1;
      hold_two <= k_two;
    end
  end

  assign triangle.valid = hold;
  assign triangle.data  = sent_first ? h_t1 : h_t0;
endmodule
`default_nettype wire

// ===== design/qts_checker.sv =====
// Port-level checker for the quad-to-triangle splitter, bound to the top.
// Depends on qts_pkg and qts_if.
`default_nettype none
module qts_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic tri_valid,
  input wire logic tri_ready,
  input wire qts_pkg::tri_t tri_data
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    tri_valid && !tri_ready |=> tri_valid && $stable(tri_data))
    else $error("triangle beat changed while stalled");
  a_coll_last: assert property (@(posedge clk) disable iff (rst)
    tri_valid && tri_data.collapsed |-> tri_data.last)
    else $error("collapsed triangle not last");
  a_pair: assert property (@(posedge clk) disable iff (rst)
    tri_valid && tri_ready && !tri_data.last |=> tri_valid && tri_data.last)
    else $error("first triangle not followed by second");
endmodule

bind quad_to_triangle_split_top qts_checker u_chk (
  .clk(clk), .rst(rst), .tri_valid(triangle.valid), .tri_ready(triangle.ready),
  .tri_data(triangle.data)
);
`default_nettype wire
